// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   // raw pair sums and differences
   localparam int D_W       = IN_W + 1;
   // square-root argument: ONE plus three entries, signed
   localparam int ARG_W     = IN_W + 3;
   localparam int ROOT_W    = (ARG_W + FRAC_BITS) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int QUO_W     = IN_W - 1;
   localparam int DIV_A     = D_W + FRAC_BITS;
   localparam int DIV_B     = DEN_W + QUO_W;
   localparam int DIV_W     = ((DIV_A > DIV_B) ? DIV_A : DIV_B) + 1;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   typedef struct packed {
      logic signed [IN_W-1:0] r00;
      logic signed [IN_W-1:0] r01;
      logic signed [IN_W-1:0] r02;
      logic signed [IN_W-1:0] r10;
      logic signed [IN_W-1:0] r11;
      logic signed [IN_W-1:0] r12;
      logic signed [IN_W-1:0] r20;
      logic signed [IN_W-1:0] r21;
      logic signed [IN_W-1:0] r22;
   } req_type;

   typedef struct packed {
      logic signed [IN_W-1:0] qw;
      logic signed [IN_W-1:0] qx;
      logic signed [IN_W-1:0] qy;
      logic signed [IN_W-1:0] qz;
      logic [1:0]             branch_used;
      logic                   degenerate;
   } rsp_type;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion, four-branch method, Q2.14 in and out.
// Fully pipelined: one matrix per cycle unless the response is stalled.
// An accepted request beat passes through an input register, branch
// select, a 16-stage bit-per-stage square root, operand prep, a 15-stage
// bit-per-stage divider per component and an output register. A stalled
// response freezes the whole pipe; req_stall is high only then. When the
// square-root argument is not positive the components are zero and
// degenerate is set; branch_used still reports the chosen branch.
module rotation_matrix_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   localparam int DEPTH = ROOT_W + QUO_W + 3;

   typedef struct packed {
      logic [3:0][D_W-1:0] d;
      logic [1:0]          br;
      logic                degen;
   } sq_side_type;

   typedef struct packed {
      logic [3:0]          neg;
      logic [3:0]          clamp;
      logic [1:0]          br;
      logic                degen;
      logic [ROOT_W-2:0]   own;
   } dv_side_type;

   logic                adv;
   logic [DEPTH-1:0]    valid_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   req_type             in_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [RAD_W-1:0]    rad_in;
   sq_side_type         s1_ff;
   sq_side_type         s1_in;
   sq_side_type         sq_side_ff [ROOT_W];
   logic [ROOT_W-1:0]   root;

   logic [DIV_W-1:0]    num_ff [4];
   logic [DIV_W-1:0]    num_in [4];
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    den_in;
   dv_side_type         pr_ff;
   dv_side_type         pr_in;
   dv_side_type         dv_side_ff [QUO_W];
   logic [QUO_W-1:0]    quo [4];

   // the whole pipe moves unless a finished beat is held at the output
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[DEPTH-2:0], req_valid};
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   // branch select, argument and pair terms
   always_comb begin
      logic signed [ARG_W-1:0] e00, e11, e22, tr, arg;
      logic signed [D_W-1:0]   e01, e02, e10, e12, e20, e21;
      e00 = ARG_W'(in_ff.r00);
      e11 = ARG_W'(in_ff.r11);
      e22 = ARG_W'(in_ff.r22);
      e01 = D_W'(in_ff.r01);
      e02 = D_W'(in_ff.r02);
      e10 = D_W'(in_ff.r10);
      e12 = D_W'(in_ff.r12);
      e20 = D_W'(in_ff.r20);
      e21 = D_W'(in_ff.r21);
      tr  = e00 + e11 + e22;
      s1_in.d = '0;
      if (tr > 0) begin
         s1_in.br   = BR_TRACE;
         arg        = ARG_W'(1 << FRAC_BITS) + tr;
         s1_in.d[1] = e21 - e12;
         s1_in.d[2] = e02 - e20;
         s1_in.d[3] = e10 - e01;
      end else if (in_ff.r00 > in_ff.r11 && in_ff.r00 > in_ff.r22) begin
         s1_in.br   = BR_X;
         arg        = ARG_W'(1 << FRAC_BITS) + e00 - e11 - e22;
         s1_in.d[0] = e21 - e12;
         s1_in.d[2] = e01 + e10;
         s1_in.d[3] = e02 + e20;
      end else if (in_ff.r11 > in_ff.r22) begin
         s1_in.br   = BR_Y;
         arg        = ARG_W'(1 << FRAC_BITS) + e11 - e00 - e22;
         s1_in.d[0] = e02 - e20;
         s1_in.d[1] = e01 + e10;
         s1_in.d[3] = e12 + e21;
      end else begin
         s1_in.br   = BR_Z;
         arg        = ARG_W'(1 << FRAC_BITS) + e22 - e00 - e11;
         s1_in.d[0] = e10 - e01;
         s1_in.d[1] = e02 + e20;
         s1_in.d[2] = e12 + e21;
      end
      s1_in.degen = arg[ARG_W-1] || (arg == '0);
      rad_in      = s1_in.degen ? '0 : (RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff  <= req_data;
         s1_ff  <= s1_in;
         rad_ff <= rad_in;
         sq_side_ff[0] <= s1_ff;
         for (int k = 1; k < ROOT_W; k++) sq_side_ff[k] <= sq_side_ff[k-1];
      end
   end

   rmq_sqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .rad_in   (rad_ff),
      .root_out (root)
   );

   // divisor s = 2h; magnitudes, signs and overflow flags per component
   always_comb begin
      logic [D_W-1:0] mag;
      sq_side_type    sd;
      sd           = sq_side_ff[ROOT_W-1];
      den_in       = {root, 1'b0};
      pr_in.br     = sd.br;
      pr_in.degen  = sd.degen;
      pr_in.own    = root[ROOT_W-1:1];
      for (int k = 0; k < 4; k++) begin
         pr_in.neg[k]   = sd.d[k][D_W-1];
         mag            = sd.d[k][D_W-1] ? (D_W'(0) - sd.d[k]) : sd.d[k];
         num_in[k]      = DIV_W'(mag) << FRAC_BITS;
         pr_in.clamp[k] = num_in[k] >= (DIV_W'(den_in) << QUO_W);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) num_ff[k] <= num_in[k];
         den_ff        <= den_in;
         pr_ff         <= pr_in;
         dv_side_ff[0] <= pr_ff;
         for (int k = 1; k < QUO_W; k++) dv_side_ff[k] <= dv_side_ff[k-1];
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_div
      rmq_div u_div (
         .clock   (clock),
         .enable  (adv),
         .num_in  (num_ff[g]),
         .den_in  (den_ff),
         .quo_out (quo[g])
      );
   end

   // sign, saturation and the branch's own component
   always_comb begin
      logic signed [IN_W-1:0] q [4];
      logic signed [IN_W-1:0] own_sat;
      dv_side_type            sd;
      sd = dv_side_ff[QUO_W-1];
      if (ROOT_W'(sd.own) > ROOT_W'({1'b0, {(IN_W-1){1'b1}}})) begin
         own_sat = {1'b0, {(IN_W-1){1'b1}}};
      end else begin
         own_sat = IN_W'(sd.own);
      end
      for (int k = 0; k < 4; k++) begin
         if (sd.degen) begin
            q[k] = '0;
         end else if (sd.br == 2'(k)) begin
            q[k] = own_sat;
         end else if (sd.clamp[k]) begin
            q[k] = sd.neg[k] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
         end else if (sd.neg[k]) begin
            q[k] = IN_W'(0) - {1'b0, quo[k]};
         end else begin
            q[k] = {1'b0, quo[k]};
         end
      end
      rsp_in.qw          = q[0];
      rsp_in.qx          = q[1];
      rsp_in.qy          = q[2];
      rsp_in.qz          = q[3];
      rsp_in.branch_used = sd.br;
      rsp_in.degenerate  = sd.degen;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [rmq_pkg::RAD_W-1:0]  rad_in,
   output logic [rmq_pkg::ROOT_W-1:0] root_out
);
   import rmq_pkg::*;

   logic [RAD_W-1:0] v_ff  [ROOT_W];
   logic [RAD_W-1:0] r_ff  [ROOT_W];
   logic [RAD_W-1:0] v_in  [ROOT_W];
   logic [RAD_W-1:0] r_in  [ROOT_W];
   logic [RAD_W-1:0] v_cur [ROOT_W];
   logic [RAD_W-1:0] r_cur [ROOT_W];

   // one result bit per stage, bit weights walk down by four
   always_comb begin
      logic [RAD_W-1:0] b;
      logic [RAD_W:0]   t;
      for (int j = 0; j < ROOT_W; j++) begin
         if (j == 0) begin
            v_cur[j] = rad_in;
            r_cur[j] = '0;
         end else begin
            v_cur[j] = v_ff[j-1];
            r_cur[j] = r_ff[j-1];
         end
         b = RAD_W'(1) << (2 * (ROOT_W - 1 - j));
         t = {1'b0, r_cur[j]} + {1'b0, b};
         if ({1'b0, v_cur[j]} >= t) begin
            v_in[j] = v_cur[j] - t[RAD_W-1:0];
            r_in[j] = (r_cur[j] >> 1) + b;
         end else begin
            v_in[j] = v_cur[j];
            r_in[j] = r_cur[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < ROOT_W; j++) begin
            v_ff[j] <= v_in[j];
            r_ff[j] <= r_in[j];
         end
      end
   end

   assign root_out = r_ff[ROOT_W-1][ROOT_W-1:0];

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [rmq_pkg::DIV_W-1:0] num_in,
   input  logic [rmq_pkg::DEN_W-1:0] den_in,
   output logic [rmq_pkg::QUO_W-1:0] quo_out
);
   import rmq_pkg::*;

   logic [DIV_W-1:0] rem_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [DIV_W-1:0] rem_in  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];
   logic [DIV_W-1:0] rem_cur [QUO_W];
   logic [DEN_W-1:0] den_cur [QUO_W];
   logic [QUO_W-1:0] quo_cur [QUO_W];

   // restoring division, one quotient bit per stage, MSB first
   always_comb begin
      logic [DIV_W-1:0] sh;
      for (int j = 0; j < QUO_W; j++) begin
         if (j == 0) begin
            rem_cur[j] = num_in;
            den_cur[j] = den_in;
            quo_cur[j] = '0;
         end else begin
            rem_cur[j] = rem_ff[j-1];
            den_cur[j] = den_ff[j-1];
            quo_cur[j] = quo_ff[j-1];
         end
         sh        = DIV_W'(den_cur[j]) << (QUO_W - 1 - j);
         rem_in[j] = rem_cur[j];
         quo_in[j] = quo_cur[j];
         if (rem_cur[j] >= sh) begin
            rem_in[j]                = rem_cur[j] - sh;
            quo_in[j][QUO_W - 1 - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_cur[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

// ===== rtl/rmq_check.sv =====
module rmq_check (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response beat changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.qw == '0 && rsp_data.qx == '0 && rsp_data.qy == '0 && rsp_data.qz == '0)
      else $error("degenerate beat with nonzero components");

   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate && rsp_data.branch_used == BR_TRACE
         |-> !rsp_data.qw[IN_W-1])
      else $error("negative scalar part on trace branch");

endmodule

bind rotation_matrix_to_quaternion rmq_check u_rmq_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
